### rtl/tpq_pkg.sv
// Shared types, constants and codes for the two-class priority queue.
package tpq_pkg;

   localparam int CAPACITY = 16;
   localparam int BATCH    = 4;
   localparam int TAG_W    = 32;
   localparam int OCC_W    = 5;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // request opcodes
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_CALL   = 2'd2
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   // controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_CHK,
      S_INS_MOV,
      S_RM_CHK,
      S_RM_CMP,
      S_RM_SH,
      S_RM_MOV,
      S_POP_RD,
      S_POP_EMIT,
      S_EMIT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic             load_req;
      logic             rd_en;
      logic [IDX_W-1:0] rd_idx;
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      logic             wr_new;
      logic             cnt_inc;
      logic             cnt_dec;
      logic             fast_inc;
      logic             fast_dec;
      logic             head_adv;
      logic             emit;
      logic             emit_pop;
      logic             emit_last;
      status_type       emit_status;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] nfast;
      logic             rd_fast;
      logic             tag_match;
      logic             req_fast;
      logic             out_free;
   } stat_type;

endpackage

### rtl/two_class_priority_queue.sv
// Two-class priority queue: a full insert or an empty call goes straight to its result, a regular
// insert writes at the tail, and a fast-track insert first moves each regular entry back a slot.
// Remove scans the entries for the tag and shifts the later ones forward; a call pops up to BATCH
// tags from the head, reading and then emitting each, and waits while a result is not taken. A
// new item is taken once the last result is loaded; the entry memory is single-port.
// Synchronous active-high reset empties the queue and drops any pending result.
module two_class_priority_queue import tpq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_op,
   input  logic [TAG_W-1:0] req_name_tag,
   input  logic             req_fast_track,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [TAG_W-1:0] rsp_out_tag,
   output logic             rsp_last,
   output logic [OCC_W-1:0] rsp_occupancy
);

   cmd_type  cmd;
   stat_type stat;

   tpq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   tpq_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_name_tag   (req_name_tag),
      .req_fast_track (req_fast_track),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_out_tag    (rsp_out_tag),
      .rsp_last       (rsp_last),
      .rsp_occupancy  (rsp_occupancy)
   );

   // fast-track count never exceeds the entry count, which stays within capacity
   a_counts: assert property (@(posedge clock) disable iff (reset)
      (stat.nfast <= stat.count) && (stat.count <= CNT_W'(CAPACITY)))
      else $error("queue counters out of range");

   // a valid operation keeps the block busy on the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready &&
       (req_op == OP_INSERT || req_op == OP_REMOVE || req_op == OP_CALL))
      |=> !req_ready)
      else $error("block ready right after taking an operation");

   // only popped entries carry a tag, and an error result is always marked last
   a_tag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_out_tag == '0 && rsp_last))
      else $error("error result with tag or without last");

   // a new result is never loaded over one that has not been taken
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("result register overwritten");

endmodule

### rtl/tpq_datapath.sv
// Entry memory, queue pointers, request latch and result register.
module tpq_datapath import tpq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [TAG_W-1:0] req_name_tag,
   input  logic             req_fast_track,
   input  cmd_type          cmd,
   output stat_type         stat,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [TAG_W-1:0] rsp_out_tag,
   output logic             rsp_last,
   output logic [OCC_W-1:0] rsp_occupancy
);

   // logical queue position to physical memory address (circular buffer)
   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                             input logic [IDX_W-1:0] pos);
      logic [IDX_W:0] sum;
      sum = {1'b0, head} + {1'b0, pos};
      if (sum >= (IDX_W+1)'(CAPACITY)) begin
         sum = sum - (IDX_W+1)'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   logic [TAG_W:0]     mem [CAPACITY];
   logic [TAG_W:0]     rd_data_ff;
   logic [TAG_W-1:0]   req_tag_ff;
   logic               req_fast_ff;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   nfast_ff, nfast_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic [TAG_W-1:0]   rsp_tag_ff;
   logic               rsp_last_ff;
   logic [OCC_W-1:0]   rsp_occ_ff;
   logic               out_free;

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_tag_ff  <= req_name_tag;
         req_fast_ff <= req_fast_track;
      end
   end

   // entry memory: one write or one read per cycle, registered read data
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[phys(head_ff, cmd.wr_idx)] <= cmd.wr_new ? {req_fast_ff, req_tag_ff}
                                                      : rd_data_ff;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[phys(head_ff, cmd.rd_idx)];
      end
   end

   // pointer and counter updates
   always_comb begin
      head_in  = cmd.head_adv ? phys(head_ff, IDX_W'(1)) : head_ff;
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
      nfast_in = nfast_ff;
      if (cmd.fast_inc) begin
         nfast_in = nfast_ff + CNT_W'(1);
      end else if (cmd.fast_dec) begin
         nfast_in = nfast_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         nfast_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         nfast_ff <= nfast_in;
      end
   end

   // result register; occupancy is the count after this result's update
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= cmd.emit_status;
         rsp_tag_ff    <= cmd.emit_pop ? rd_data_ff[TAG_W-1:0] : '0;
         rsp_last_ff   <= cmd.emit_last;
         rsp_occ_ff    <= OCC_W'(count_in);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_tag   = rsp_tag_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_occupancy = rsp_occ_ff;

   // status back to the controller
   always_comb begin
      stat.count     = count_ff;
      stat.nfast     = nfast_ff;
      stat.rd_fast   = rd_data_ff[TAG_W];
      stat.tag_match = (rd_data_ff[TAG_W-1:0] == req_tag_ff);
      stat.req_fast  = req_fast_ff;
      stat.out_free  = out_free;
   end

endmodule

### rtl/tpq_controller.sv
// Sequencer for insert, remove-by-tag and batch pop operations.
module tpq_controller import tpq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_op,
   output logic       req_ready,
   output cmd_type    cmd,
   input  stat_type   stat
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   status_type       st_ff, st_in;
   logic [CNT_W-1:0] ins_target;
   logic             accept;
   logic             pop_last;

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   // fast-track entries go behind the last fast one, regular ones at the tail
   assign ins_target = stat.req_fast ? stat.nfast : stat.count;
   assign pop_last   = (int'(idx_ff) + 1 == BATCH) || (stat.count == CNT_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_INSERT: state_in = (stat.count == CNT_W'(CAPACITY)) ? S_EMIT
                                                                          : S_INS_CHK;
                  OP_REMOVE: state_in = S_RM_CHK;
                  OP_CALL:   state_in = (stat.count == '0) ? S_EMIT : S_POP_RD;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_INS_CHK:  state_in = (idx_ff == ins_target) ? S_EMIT : S_INS_MOV;
         S_INS_MOV:  state_in = S_INS_CHK;
         S_RM_CHK:   state_in = (idx_ff == stat.count) ? S_EMIT : S_RM_CMP;
         S_RM_CMP:   state_in = stat.tag_match ? S_RM_SH : S_RM_CHK;
         S_RM_SH:    state_in = (idx_ff + CNT_W'(1) == stat.count) ? S_EMIT : S_RM_MOV;
         S_RM_MOV:   state_in = S_RM_SH;
         S_POP_RD:   state_in = S_POP_EMIT;
         S_POP_EMIT: begin
            if (stat.out_free) begin
               state_in = pop_last ? S_IDLE : S_POP_RD;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd             = '0;
      cmd.emit_status = ST_OK;
      cmd.load_req    = accept;
      case (state_ff)
         S_INS_CHK: begin
            cmd.wr_idx = idx_ff[IDX_W-1:0];
            if (idx_ff == ins_target) begin
               cmd.wr_en    = 1'b1;
               cmd.wr_new   = 1'b1;
               cmd.cnt_inc  = 1'b1;
               cmd.fast_inc = stat.req_fast;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_idx = IDX_W'(idx_ff - CNT_W'(1));
            end
         end
         S_INS_MOV: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_idx = idx_ff[IDX_W-1:0];
         end
         S_RM_CHK: begin
            cmd.rd_en  = (idx_ff != stat.count);
            cmd.rd_idx = idx_ff[IDX_W-1:0];
         end
         S_RM_CMP: begin
            cmd.fast_dec = stat.tag_match && stat.rd_fast;
         end
         S_RM_SH: begin
            if (idx_ff + CNT_W'(1) == stat.count) begin
               cmd.cnt_dec = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_idx = IDX_W'(idx_ff + CNT_W'(1));
            end
         end
         S_RM_MOV: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_idx = idx_ff[IDX_W-1:0];
         end
         S_POP_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_idx = '0;
         end
         S_POP_EMIT: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_pop  = 1'b1;
               cmd.emit_last = pop_last;
               cmd.head_adv  = 1'b1;
               cmd.cnt_dec   = 1'b1;
               cmd.fast_dec  = stat.rd_fast;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_last   = 1'b1;
               cmd.emit_status = st_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // position counter and pending status
   always_comb begin
      idx_in = idx_ff;
      st_in  = st_ff;
      case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (accept) begin
               case (req_op)
                  OP_INSERT: begin
                     idx_in = stat.count;
                     st_in  = ST_FULL;
                  end
                  OP_REMOVE: st_in = ST_NOTFOUND;
                  OP_CALL:   st_in = ST_EMPTY;
                  default:   st_in = st_ff;
               endcase
            end
         end
         S_INS_CHK: begin
            st_in = ST_OK;
         end
         S_INS_MOV: idx_in = idx_ff - CNT_W'(1);
         S_RM_CMP: begin
            if (!stat.tag_match) begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         S_RM_SH: begin
            st_in = ST_OK;
         end
         S_RM_MOV: idx_in = idx_ff + CNT_W'(1);
         S_POP_EMIT: begin
            if (stat.out_free) begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         st_ff    <= ST_OK;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         st_ff    <= st_in;
      end
   end

endmodule
